FILE: sv/bavg_pkg.sv
// bavg_pkg: shared widths, register indexes, reset values and the
// stage-to-stage record for the 4x4 block averaging downsampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bavg_pkg;

    localparam int PIX_W = 16;
    localparam int SUM_W = 18;
    localparam int CFG_W = 11;
    localparam int IDX_W = 2;
    localparam int ROW_W = 10;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // register reset values and size limits
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;
    localparam logic [CFG_W-1:0] MIN_SIZE     = 11'd4;

    typedef logic signed [SUM_W-1:0] sum_t;

    // what the front end hands to the line store stage
    typedef struct packed {
        logic                    run_end;
        logic [1:0]              block_row;
        logic                    frame_done;
        logic signed [PIX_W-1:0] row_mean;
    } run_info_t;

    // divide by four, truncating toward zero
    function automatic sum_t div4_trunc(input sum_t x);
        sum_t biased;
        biased = x + (x[SUM_W-1] ? sum_t'(3) : sum_t'(0));
        return biased >>> 2;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bavg_line_store.sv
// bavg_line_store: one entry per block column holding the running sum of
// row means; synchronous read with write forwarding.
// Depends on bavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bavg_line_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output bavg_pkg::sum_t            rd_data,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire bavg_pkg::sum_t       wr_data
);

    bavg_pkg::sum_t mem [DEPTH];
    bavg_pkg::sum_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, newest data wins on an address match
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/bavg_front.sv
// bavg_front: size registers, raster position counters and the four-pixel
// run sum; flags the end of each run with its truncated row mean.
// Depends on bavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bavg_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bavg_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [bavg_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        accept,
    input  wire logic signed [bavg_pkg::PIX_W-1:0] pixel_value,
    output bavg_pkg::run_info_t              info,
    output logic [CW-3:0]                    slot
);

    localparam int EW_MIN = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (EW_MIN > bavg_pkg::CFG_W) ? EW_MIN : bavg_pkg::CFG_W;
    localparam logic [EW-1:0] MAX_W4 = EW'((MAX_WIDTH / 4) * 4);

    logic [bavg_pkg::CFG_W-1:0] width_reg, width_next;
    logic [bavg_pkg::CFG_W-1:0] height_reg, height_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [bavg_pkg::ROW_W-1:0] row_reg, row_next;
    bavg_pkg::sum_t             run_sum_reg, run_sum_next;

    logic [EW-1:0]              w_raw, eff_w, col_inc;
    logic [bavg_pkg::CFG_W-1:0] h_raw, eff_h, row_inc;
    logic                       last_col, last_row;
    bavg_pkg::sum_t             pix_ext, run_total, mean_full;

    // configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                bavg_pkg::REG_FRAME_WIDTH:  width_next  = cfg_data;
                bavg_pkg::REG_FRAME_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size, low bits dropped, zero taken as one block, capped at the maximum
    assign w_raw = EW'({width_reg[bavg_pkg::CFG_W-1:2], 2'b00});
    assign eff_w = (w_raw == '0) ? EW'(4) : ((w_raw > MAX_W4) ? MAX_W4 : w_raw);
    assign h_raw = {height_reg[bavg_pkg::CFG_W-1:2], 2'b00};
    assign eff_h = (h_raw == '0) ? bavg_pkg::MIN_SIZE :
                   ((h_raw > bavg_pkg::HEIGHT_LIMIT) ? bavg_pkg::HEIGHT_LIMIT : h_raw);

    // position within the frame
    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_inc  = bavg_pkg::CFG_W'(row_reg) + bavg_pkg::CFG_W'(1);
    assign last_col = (col_inc >= eff_w);
    assign last_row = (row_inc >= eff_h);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[bavg_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // four-pixel run sum, restarted at each block column boundary
    assign pix_ext   = bavg_pkg::sum_t'(pixel_value);
    assign run_total = (col_reg[1:0] == 2'd0) ? pix_ext : (run_sum_reg + pix_ext);
    assign mean_full = bavg_pkg::div4_trunc(run_total);
    assign run_sum_next = accept ? run_total : run_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bavg_pkg::WIDTH_RESET;
            height_reg  <= bavg_pkg::HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            run_sum_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            run_sum_reg <= run_sum_next;
        end
    end

    // run end record for the line store stage
    assign info.run_end    = (col_reg[1:0] == 2'd3);
    assign info.block_row  = row_reg[1:0];
    assign info.frame_done = last_col && last_row;
    assign info.row_mean   = mean_full[bavg_pkg::PIX_W-1:0];
    assign slot            = col_reg[CW-1:2];

endmodule

`default_nettype wire

FILE: sv/block_average_downsample_4x4.sv
// block_average_downsample_4x4: top level of the 4x4 block averaging
// downsampler. Depends on bavg_pkg, bavg_front and bavg_line_store.
//
// Usage:
//   Pixels enter in raster order on in_valid / in_stall / pixel_value; a
//   transaction completes on a clock edge with in_valid high and in_stall
//   low. One 4x4 block mean leaves on out_valid / out_stall / block_mean,
//   with frame_done set on the last block of the frame.
//   Sizes are written through cfg_wr_en / cfg_index / cfg_data while idle.
//   Throughput: one pixel per cycle while in_stall is low, with one line store
//   read and at most one write-back per four-pixel run. A block's last pixel
//   is registered into the accumulate stage, and its result then into the
//   output register, where out_valid rises.
//   A stalled result is held in the output register; the line store stage
//   keeps working and holds in_stall only when its own result cannot move
//   on, so the input stalls at most while a second result is queued.
//   Reset (rst_n, asynchronous) clears counters, sizes (640 x 480) and the
//   pipeline valids; the line store needs no clearing, since each block's
//   first row writes its entry without using the value read.
`timescale 1ns / 1ps
`default_nettype none

module block_average_downsample_4x4 #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bavg_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [bavg_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [bavg_pkg::PIX_W-1:0]  pixel_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [bavg_pkg::PIX_W-1:0]       block_mean,
    output logic                                    frame_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = CW - 2;
    localparam int DEPTH = MAX_WIDTH / 4;

    logic                in_acc;
    bavg_pkg::run_info_t re_info;
    logic [SW-1:0]       re_slot;

    logic                s1_valid_reg, s1_valid_next;
    bavg_pkg::run_info_t s1_info_reg;
    logic [SW-1:0]       s1_slot_reg;
    logic                s1_is_result, s1_go;

    bavg_pkg::sum_t      held, mean_ext, s1_sum, s1_result, wr_data;
    logic                rd_en, wr_en;

    logic                out_valid_reg, out_valid_next;
    logic signed [bavg_pkg::PIX_W-1:0] out_mean_reg;
    logic                out_done_reg;

    assign in_acc = in_valid && !in_stall;

    bavg_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (in_acc),
        .pixel_value (pixel_value),
        .info        (re_info),
        .slot        (re_slot)
    );

    // line store read issued with the run's last pixel
    assign rd_en = in_acc && re_info.run_end;

    bavg_line_store #(
        .DEPTH (DEPTH),
        .AW    (SW)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (re_slot),
        .rd_data (held),
        .wr_en   (wr_en),
        .wr_addr (s1_slot_reg),
        .wr_data (wr_data)
    );

    // accumulate stage: add row mean to the held sum (first row starts anew), write back or finish
    assign mean_ext     = bavg_pkg::sum_t'(s1_info_reg.row_mean);
    assign s1_sum       = held + mean_ext;
    assign s1_result    = bavg_pkg::div4_trunc(s1_sum);
    assign s1_is_result = (s1_info_reg.block_row == 2'd3);
    assign s1_go        = s1_valid_reg && (!s1_is_result || !out_valid_reg || !out_stall);
    assign wr_en        = s1_go && !s1_is_result;
    assign wr_data      = (s1_info_reg.block_row == 2'd0) ? mean_ext : s1_sum;
    assign in_stall     = s1_valid_reg && !s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = re_info.run_end;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && re_info.run_end)
        begin
            s1_info_reg <= re_info;
            s1_slot_reg <= re_slot;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_is_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_is_result)
        begin
            out_mean_reg <= s1_result[bavg_pkg::PIX_W-1:0];
            out_done_reg <= s1_info_reg.frame_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_mean = out_mean_reg;
    assign frame_done = out_done_reg;

`ifndef SYNTH
    // run ends are never taken on two consecutive edges
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && re_info.run_end) |=> !(in_acc && re_info.run_end))
        else $error("run end accepted twice in a row");

    // a read and a write-back never hit the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (re_slot == s1_slot_reg)))
        else $error("line store read and write collide");

    // a new result only comes out of the accumulate stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without accumulate stage");
`endif

endmodule

`default_nettype wire
